// File: hw/rtl/hwim_pkg.sv
// Package for the hit window interval merger.
// Holds widths, reset values, the queue word type and the control structs.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package hwim_pkg;

    // Field widths.
    localparam int TIME_W  = 30;
    localparam int HW_W    = 20;
    localparam int RANGE_W = 32;

    // Default store depth and reset value of the half window.
    localparam int            MAX_HITS_DEF    = 64;
    localparam logic [HW_W-1:0] HALF_WINDOW_RST = 20'd32000;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic [TIME_W-1:0] hit_time;
        logic              has_hit;
        logic              last;
    } t_cmd;

    // Control from the merge sequencer to the sorter.
    typedef struct packed {
        logic              ins;
        logic              shift;
        logic [TIME_W-1:0] ins_time;
    } t_srt_ctrl;

    // Status from the sorter to the merge sequencer.
    typedef struct packed {
        logic [TIME_W-1:0] head;
        logic              head_vld;
        logic              full;
    } t_srt_stat;

    // Merge sequencer states.
    typedef enum logic [1:0] {
        S_RUN,
        S_START,
        S_WALK
    } t_state;

endpackage

// File: hw/rtl/hit_window_interval_merger.sv
// Top level of the hit window interval merger.
// Instantiates hwim_front, hwim_sorter and hwim_merge; holds the half window register.
// Depends on hwim_pkg.
//
//  Channel   Handshake                 Word
//  -------   -----------------------   --------------------------------------------
//  input     push / full               i_hit_time, i_carries_hit, i_last_hit
//  result    empty / pop               o_range_low, o_range_high, o_last_range,
//                                      o_overflowed
//  config    i_cfg_valid / o_cfg_ready i_cfg_half_window
//
// Loading inserts each queued hit into the sorter, which puts a time in place each cycle.
// On the last word, merging starts once that word leaves the queue; the sorter head is drained
// one entry a cycle unless a new range waits on a full output register, and a four-word queue
// keeps taking input meanwhile. A full output register stalls each range emit until pop.
// Reset is synchronous and active low; the store comes up empty, the half window at 32000.
`timescale 1ns / 1ps

module hit_window_interval_merger #(
    parameter int MAX_HITS = hwim_pkg::MAX_HITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [hwim_pkg::TIME_W-1:0]        i_hit_time,
    input  logic                               i_carries_hit,
    input  logic                               i_last_hit,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [hwim_pkg::RANGE_W-1:0] o_range_low,
    output logic signed [hwim_pkg::RANGE_W-1:0] o_range_high,
    output logic                               o_last_range,
    output logic                               o_overflowed,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hwim_pkg::HW_W-1:0]          i_cfg_half_window
);
    import hwim_pkg::*;

    logic [HW_W-1:0] r_half_window;
    t_cmd            q_cmd;
    logic            q_valid;
    logic            q_pop;
    t_srt_ctrl       srt_ctrl;
    t_srt_stat       srt_stat;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= HALF_WINDOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_half_window <= i_cfg_half_window;
        end
    end

    hwim_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_hit_time    (i_hit_time),
        .i_carries_hit (i_carries_hit),
        .i_last_hit    (i_last_hit),
        .o_q_cmd       (q_cmd),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop)
    );

    hwim_sorter #(
        .MAX_HITS (MAX_HITS)
    ) u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (srt_ctrl),
        .o_stat  (srt_stat)
    );

    hwim_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_cmd       (q_cmd),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .o_srt_ctrl    (srt_ctrl),
        .i_srt_stat    (srt_stat),
        .i_half_window (r_half_window),
        .empty         (empty),
        .pop           (pop),
        .o_range_low   (o_range_low),
        .o_range_high  (o_range_high),
        .o_last_range  (o_last_range),
        .o_overflowed  (o_overflowed)
    );

endmodule

// File: hw/rtl/hwim_front.sv
// Front part of the merger: accepts input words and queues those that matter.
// Words with neither a hit nor the last mark are taken and discarded.
// Depends on hwim_pkg.
`timescale 1ns / 1ps

module hwim_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [hwim_pkg::TIME_W-1:0] i_hit_time,
    input  logic                        i_carries_hit,
    input  logic                        i_last_hit,
    output hwim_pkg::t_cmd              o_q_cmd,
    output logic                        o_q_valid,
    input  logic                        i_q_pop
);
    import hwim_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              acc;
    logic              wr_en;
    logic              rd_en;

    // A word is taken whenever there is room; only useful words are stored.
    assign full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign acc   = push && !full;
    assign wr_en = acc && (i_carries_hit || i_last_hit);
    assign rd_en = i_q_pop && (r_cnt != '0);

    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rd];

    // Pointer and fill count updates.
    always_comb begin
        n_wr  = wr_en ? QPTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = rd_en ? QPTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = QCNT_W'(r_cnt + 1'b1);
        end else if (!wr_en && rd_en) begin
            n_cnt = QCNT_W'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= '{hit_time: i_hit_time, has_hit: i_carries_hit, last: i_last_hit};
        end
    end

endmodule

// File: hw/rtl/hwim_sorter.sv
// Insertion sorter: a row of cells kept in ascending order.
// A new time enters directly at its place; the row shifts toward cell 0 to drain.
// Depends on hwim_pkg.
`timescale 1ns / 1ps

module hwim_sorter #(
    parameter int MAX_HITS = hwim_pkg::MAX_HITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hwim_pkg::t_srt_ctrl  i_ctrl,
    output hwim_pkg::t_srt_stat  o_stat
);
    import hwim_pkg::*;

    logic [TIME_W-1:0] r_val [MAX_HITS];
    logic [TIME_W-1:0] n_val [MAX_HITS];
    logic [MAX_HITS-1:0] r_vld, n_vld;
    logic [MAX_HITS-1:0] gt;

    // A cell moves aside when it holds a larger time or is empty.
    always_comb begin
        for (int i = 0; i < MAX_HITS; i++) begin
            gt[i] = !r_vld[i] || (r_val[i] > i_ctrl.ins_time);
        end
    end

    // Next contents of every cell.
    always_comb begin
        for (int i = 0; i < MAX_HITS; i++) begin
            n_val[i] = r_val[i];
        end
        n_vld = r_vld;
        if (i_ctrl.ins) begin
            n_vld = {r_vld[MAX_HITS-2:0], 1'b1};
            for (int i = 0; i < MAX_HITS; i++) begin
                if (gt[i]) begin
                    if (i == 0) begin
                        n_val[i] = i_ctrl.ins_time;
                    end else if (!gt[i-1]) begin
                        n_val[i] = i_ctrl.ins_time;
                    end else begin
                        n_val[i] = r_val[i-1];
                    end
                end
            end
        end else if (i_ctrl.shift) begin
            n_vld = {1'b0, r_vld[MAX_HITS-1:1]};
            for (int i = 0; i < MAX_HITS - 1; i++) begin
                n_val[i] = r_val[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_HITS; i++) begin
            r_val[i] <= n_val[i];
        end
    end

    assign o_stat.head     = r_val[0];
    assign o_stat.head_vld = r_vld[0];
    assign o_stat.full     = r_vld[MAX_HITS-1];

endmodule

// File: hw/rtl/hwim_merge.sv
// Back part of the merger: loads queued hits into the sorter and, on the last
// word of a set, drains the sorter while merging windows into the output register.
// Depends on hwim_pkg.
`timescale 1ns / 1ps

module hwim_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hwim_pkg::t_cmd                i_q_cmd,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    output hwim_pkg::t_srt_ctrl           o_srt_ctrl,
    input  hwim_pkg::t_srt_stat           i_srt_stat,
    input  logic [hwim_pkg::HW_W-1:0]     i_half_window,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [hwim_pkg::RANGE_W-1:0] o_range_low,
    output logic signed [hwim_pkg::RANGE_W-1:0] o_range_high,
    output logic                          o_last_range,
    output logic                          o_overflowed
);
    import hwim_pkg::*;

    t_state r_state, n_state;

    logic                      r_drop;
    logic signed [RANGE_W-1:0] r_cur_lo;
    logic signed [RANGE_W-1:0] r_cur_hi;
    logic                      r_out_vld;

    logic signed [RANGE_W-1:0] head_lo;
    logic signed [RANGE_W-1:0] head_hi;
    logic                      out_free;
    logic                      joins;

    logic                      set_drop;
    logic                      clr_drop;
    logic                      load_cur;
    logic                      grow_cur;
    logic                      emit;
    logic                      emit_last;
    logic                      emit_dummy;

    // Window bounds of the smallest stored hit.
    assign head_lo = $signed({{(RANGE_W-TIME_W){1'b0}}, i_srt_stat.head})
                   - $signed({{(RANGE_W-HW_W){1'b0}}, i_half_window});
    assign head_hi = $signed({{(RANGE_W-TIME_W){1'b0}}, i_srt_stat.head})
                   + $signed({{(RANGE_W-HW_W){1'b0}}, i_half_window});

    // The head window overlaps or touches the current range.
    assign joins    = (r_cur_hi >= head_lo);
    assign out_free = !r_out_vld || pop;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (i_q_valid && i_q_cmd.last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_srt_stat.head_vld) begin
                    n_state = S_WALK;
                end else if (out_free) begin
                    n_state = S_RUN;
                end
            end
            S_WALK: begin
                if (!i_srt_stat.head_vld && out_free) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_q_pop    = 1'b0;
        o_srt_ctrl = '{ins: 1'b0, shift: 1'b0, ins_time: i_q_cmd.hit_time};
        set_drop   = 1'b0;
        clr_drop   = 1'b0;
        load_cur   = 1'b0;
        grow_cur   = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b0;
        emit_dummy = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.has_hit) begin
                        if (i_srt_stat.full) begin
                            set_drop = 1'b1;
                        end else begin
                            o_srt_ctrl.ins = 1'b1;
                        end
                    end
                end
            end
            S_START: begin
                if (i_srt_stat.head_vld) begin
                    load_cur         = 1'b1;
                    o_srt_ctrl.shift = 1'b1;
                end else if (out_free) begin
                    // Empty set: one range from zero to zero.
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_dummy = 1'b1;
                    clr_drop   = 1'b1;
                end
            end
            S_WALK: begin
                if (!i_srt_stat.head_vld) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        clr_drop  = 1'b1;
                    end
                end else if (joins) begin
                    grow_cur         = 1'b1;
                    o_srt_ctrl.shift = 1'b1;
                end else if (out_free) begin
                    emit             = 1'b1;
                    load_cur         = 1'b1;
                    o_srt_ctrl.shift = 1'b1;
                end
            end
            default: begin
                o_q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_RUN;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (set_drop) begin
                r_drop <= 1'b1;
            end else if (clr_drop) begin
                r_drop <= 1'b0;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Current merged range.
    always_ff @(posedge i_clk) begin
        if (load_cur) begin
            r_cur_lo <= head_lo;
            r_cur_hi <= head_hi;
        end else if (grow_cur && (head_hi > r_cur_hi)) begin
            r_cur_hi <= head_hi;
        end
    end

    // Output register holding the oldest waiting word.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_range_low  <= emit_dummy ? '0 : r_cur_lo;
            o_range_high <= emit_dummy ? '0 : r_cur_hi;
            o_last_range <= emit_last;
            o_overflowed <= r_drop;
        end
    end

    assign empty = !r_out_vld;

endmodule
